[hdl/ads_pkg.sv]
// Shared types and constants of the advection-diffusion stencil block.
`timescale 1ns / 1ps
package ads_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int GRID_MIN      = 3;

    localparam int DATA_W     = 32;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 10;
    localparam int GW_W       = 11;
    localparam int CFG_IDX_W  = 3;

    // sequential multiplier: |a| < 2^48 in 16-bit digits, |b| < 2^32
    localparam int MUL_A_W    = 48;
    localparam int MUL_B_W    = 32;
    localparam int DIGIT_W    = 16;
    localparam int MUL_DIGITS = MUL_A_W / DIGIT_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int RES_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_ADV_X       = 3'd2,
        REG_ADV_Y       = 3'd3,
        REG_DIFF_X      = 3'd4,
        REG_DIFF_Y      = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                        start;
        logic signed [MUL_A_W:0]     a;
        logic signed [MUL_B_W:0]     b;
        logic                        round24;   // 1: Q8.24 scale, 0: Q16.16 scale
    } ads_mul_req_t;

endpackage

[hdl/advection_diffusion_stencil_step.sv]
// Top level of the streaming 2-D FTCS advection-diffusion stencil.
//
//  channel | dir | request when        | payload
//  s_      | in  | s_tvalid & s_tready | tdata: phi_in, u_vel, v_vel
//  m_      | out | m_tvalid & m_tready | tdata: out_row, out_col, phi_out; tlast
//  cfg_    | in  | cfg_valid&cfg_ready | cfg_index, cfg_data
//
// One cell at a time. An interior cell's pace is set by the shared multiplier, which
// forms six products in turn; an edge cell skips it. Line stores read through one port
// each, four phi reads per interior cell. aresetn is synchronous; line stores are not
// cleared and hold nothing valid until written. A stalled m_ holds the last result; s_
// is taken again once the final result of a cell sits in the output register and the
// cell has been written to the line stores.
`timescale 1ns / 1ps
module advection_diffusion_stencil_step #(
    parameter int MAX_WIDTH = ads_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [95:0]                       s_tdata,   // phi_in, u_vel, v_vel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // out_row, out_col, phi_out, zero pad
    output logic                              m_tlast,   // last_of_run
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ads_pkg::DATA_W-1:0]        cfg_data
);
    import ads_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW = $clog2(2 * MAX_WIDTH);
    localparam int LW = (CW + 1 > GW_W) ? CW + 1 : GW_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RD1   = 13'b0000000000010,
        S_RD2   = 13'b0000000000100,
        S_RD3   = 13'b0000000001000,
        S_RD4   = 13'b0000000010000,
        S_DIFF  = 13'b0000000100000,
        S_MUL   = 13'b0000001000000,
        S_MWAIT = 13'b0000010000000,
        S_SUM1  = 13'b0000100000000,
        S_SUM2  = 13'b0001000000000,
        S_OUT1  = 13'b0010000000000,
        S_OUT2  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } state_t;

    typedef enum logic [2:0] {
        MS_GX = 3'd0, MS_GY = 3'd1, MS_TX = 3'd2,
        MS_TY = 3'd3, MS_AU = 3'd4, MS_AV = 3'd5
    } mul_sel_t;

    state_t state_reg, state_next;
    mul_sel_t sel_reg;

    // configuration
    logic [GW_W-1:0]   grid_width_reg;
    logic [ROW_W-1:0]  grid_height_reg;
    logic [DATA_W-1:0] adv_x_reg, adv_y_reg, diff_x_reg, diff_y_reg;

    logic [CW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic signed [DATA_W-1:0] phi_in_reg, u_in_reg, v_in_reg;
    logic signed [DATA_W-1:0] ctr_reg, west_reg, east_reg, uu_reg, vv_reg;
    logic signed [MUL_A_W:0]  ew_reg, ns_reg, lx_reg, ly_reg;
    logic signed [RES_W-1:0]  gx_reg, gy_reg, tx_reg, ty_reg, au_reg, av_reg;
    logic signed [RES_W-1:0]  adv_reg, dif_reg, res_reg;

    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic               m_last_reg;

    // memories
    logic               we;
    logic [AW-1:0]      phi_raddr, phi_waddr;
    logic [DATA_W-1:0]  phi_rdata, u_rdata, v_rdata;

    ads_mul_req_t       mreq;
    logic               mdone;
    logic signed [RES_W-1:0] mres;

    logic [LW-1:0]      w_eff, col_inc;
    logic [ROW_W:0]     h_eff, row_inc;
    logic               has1, has2, interior, out_free;
    logic [AW-1:0]      base_cur, base_prev;
    logic signed [DATA_W-1:0] phi_sat;

    ads_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_WIDTH)) u_phi_ram (
        .aclk(aclk), .we(we), .waddr(phi_waddr), .wdata(phi_in_reg),
        .raddr(phi_raddr), .rdata(phi_rdata)
    );
    ads_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_u_ram (
        .aclk(aclk), .we(we), .waddr(col_reg), .wdata(u_in_reg),
        .raddr(col_reg), .rdata(u_rdata)
    );
    ads_ram #(.WIDTH(DATA_W), .DEPTH(MAX_WIDTH)) u_v_ram (
        .aclk(aclk), .we(we), .waddr(col_reg), .wdata(v_in_reg),
        .raddr(col_reg), .rdata(v_rdata)
    );

    ads_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .req(mreq), .done(mdone), .result(mres)
    );

    always_comb begin
        if (LW'(grid_width_reg) < LW'(GRID_MIN)) begin
            w_eff = LW'(GRID_MIN);
        end else if (LW'(grid_width_reg) > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = LW'(grid_width_reg);
        end
        h_eff    = (grid_height_reg < ROW_W'(GRID_MIN)) ? (ROW_W+1)'(GRID_MIN)
                                                        : {1'b0, grid_height_reg};
        col_inc  = LW'(col_reg) + LW'(1);
        row_inc  = {1'b0, row_reg} + (ROW_W+1)'(1);
        has1     = (row_reg != '0);
        has2     = (row_inc >= h_eff);
        interior = (row_reg >= ROW_W'(2)) && (col_reg != '0) && (col_inc < w_eff);
        out_free = !m_valid_reg || m_tready;
        base_cur  = row_reg[0] ? AW'(MAX_WIDTH) : '0;
        base_prev = row_reg[0] ? '0 : AW'(MAX_WIDTH);
        phi_waddr = base_cur + AW'(col_reg);
        we        = (state_reg == S_FIN);
        if (res_reg > RES_W'(64'sh7FFF_FFFF)) begin
            phi_sat = 32'sh7FFF_FFFF;
        end else if (res_reg < -RES_W'(64'sh8000_0000)) begin
            phi_sat = 32'sh8000_0000;
        end else begin
            phi_sat = res_reg[DATA_W-1:0];
        end
    end

    // phi read address per step: centre, west, east, then the row two up
    always_comb begin
        unique case (state_reg)
            S_RD1:   phi_raddr = base_prev + AW'(col_reg) - AW'(1);
            S_RD2:   phi_raddr = base_prev + AW'(col_reg) + AW'(1);
            S_RD3:   phi_raddr = base_cur + AW'(col_reg);
            default: phi_raddr = base_prev + AW'(col_reg);
        endcase
    end

    always_comb begin
        mreq.start   = (state_reg == S_MUL);
        mreq.round24 = 1'b1;
        unique case (sel_reg)
            MS_GX: begin mreq.a = ew_reg; mreq.b = {1'b0, adv_x_reg};  end
            MS_GY: begin mreq.a = ns_reg; mreq.b = {1'b0, adv_y_reg};  end
            MS_TX: begin mreq.a = lx_reg; mreq.b = {1'b0, diff_x_reg}; end
            MS_TY: begin mreq.a = ly_reg; mreq.b = {1'b0, diff_y_reg}; end
            MS_AU: begin
                mreq.a = gx_reg[MUL_A_W:0]; mreq.b = 33'(uu_reg); mreq.round24 = 1'b0;
            end
            MS_AV: begin
                mreq.a = gy_reg[MUL_A_W:0]; mreq.b = 33'(vv_reg); mreq.round24 = 1'b0;
            end
            default: begin mreq.a = '0; mreq.b = '0; end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_RD1;
            S_RD1: begin
                if (interior)  state_next = S_RD2;
                else if (has1) state_next = S_OUT1;
                else if (has2) state_next = S_OUT2;
                else           state_next = S_FIN;
            end
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_RD4;
            S_RD4:   state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_MWAIT;
            S_MWAIT: if (mdone) state_next = (sel_reg == MS_AV) ? S_SUM1 : S_MUL;
            S_SUM1:  state_next = S_SUM2;
            S_SUM2:  state_next = S_OUT1;
            S_OUT1:  if (out_free) state_next = has2 ? S_OUT2 : S_FIN;
            S_OUT2:  if (out_free) state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            sel_reg         <= MS_GX;
            col_reg         <= '0;
            row_reg         <= '0;
            m_valid_reg     <= 1'b0;
            grid_width_reg  <= GW_W'(GRID_MIN);
            grid_height_reg <= ROW_W'(GRID_MIN);
            adv_x_reg       <= '0;
            adv_y_reg       <= '0;
            diff_x_reg      <= '0;
            diff_y_reg      <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_W-1:0];
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_data[ROW_W-1:0];
                    REG_ADV_X:       adv_x_reg       <= cfg_data;
                    REG_ADV_Y:       adv_y_reg       <= cfg_data;
                    REG_DIFF_X:      diff_x_reg      <= cfg_data;
                    REG_DIFF_Y:      diff_y_reg      <= cfg_data;
                    default: ;
                endcase
            end

            if ((state_reg == S_OUT1 || state_reg == S_OUT2) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == S_DIFF) begin
                sel_reg <= MS_GX;
            end else if (state_reg == S_MWAIT && mdone && sel_reg != MS_AV) begin
                sel_reg <= mul_sel_t'(sel_reg + 3'd1);
            end

            if (state_reg == S_FIN) begin
                if (col_inc >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= has2 ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    col_reg <= col_inc[CW-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                phi_in_reg <= s_tdata[31:0];
                u_in_reg   <= s_tdata[63:32];
                v_in_reg   <= s_tdata[95:64];
            end
            S_RD1: begin
                ctr_reg <= phi_rdata;
                uu_reg  <= u_rdata;
                vv_reg  <= v_rdata;
                res_reg <= RES_W'($signed(phi_rdata));
            end
            S_RD2: west_reg <= phi_rdata;
            S_RD3: east_reg <= phi_rdata;
            S_RD4: begin
                ew_reg <= (MUL_A_W+1)'(east_reg) - (MUL_A_W+1)'(west_reg);
                ns_reg <= (MUL_A_W+1)'(phi_in_reg) - (MUL_A_W+1)'($signed(phi_rdata));
                lx_reg <= (MUL_A_W+1)'(east_reg) + (MUL_A_W+1)'(west_reg)
                        - ((MUL_A_W+1)'(ctr_reg) <<< 1);
                ly_reg <= (MUL_A_W+1)'(phi_in_reg) + (MUL_A_W+1)'($signed(phi_rdata))
                        - ((MUL_A_W+1)'(ctr_reg) <<< 1);
            end
            S_MWAIT: begin
                if (mdone) begin
                    unique case (sel_reg)
                        MS_GX:   gx_reg <= mres;
                        MS_GY:   gy_reg <= mres;
                        MS_TX:   tx_reg <= mres;
                        MS_TY:   ty_reg <= mres;
                        MS_AU:   au_reg <= mres;
                        MS_AV:   av_reg <= mres;
                        default: ;
                    endcase
                end
            end
            S_SUM1: begin
                adv_reg <= au_reg + av_reg;
                dif_reg <= tx_reg + ty_reg;
            end
            S_SUM2: res_reg <= RES_W'(ctr_reg) - adv_reg + dif_reg;
            S_OUT1: begin
                if (out_free) begin
                    m_data_reg <= {6'd0, phi_sat, COL_W'(col_reg), row_reg - ROW_W'(1)};
                    m_last_reg <= !has2;
                end
            end
            S_OUT2: begin
                if (out_free) begin
                    m_data_reg <= {6'd0, phi_in_reg, COL_W'(col_reg), row_reg};
                    m_last_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
endmodule

[hdl/ads_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/ads_mul.sv]
// Sign-magnitude multiplier, one 16-bit digit per cycle, rounding half away from zero.
`timescale 1ns / 1ps
module ads_mul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ads_pkg::ads_mul_req_t            req,
    output logic                             done,
    output logic signed [ads_pkg::RES_W-1:0] result
);
    import ads_pkg::*;

    logic [MUL_A_W-1:0]     ma_reg;
    logic [MUL_B_W-1:0]     mb_reg;
    logic                   neg_reg;
    logic                   r24_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [1:0]             cnt_reg;
    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic signed [RES_W-1:0] result_reg;

    logic [MUL_A_W:0]       abs_a;
    logic [MUL_B_W:0]       abs_b;
    logic [PROD_W:0]        rounded;
    logic [RES_W-1:0]       mag;
    logic [DIGIT_W+MUL_B_W-1:0] pp;

    always_comb begin
        abs_a = req.a[MUL_A_W] ? (~req.a + 1'b1) : req.a;
        abs_b = req.b[MUL_B_W] ? (~req.b + 1'b1) : req.b;
        // one digit times the whole multiplier, full width
        pp    = ma_reg[MUL_A_W-1 -: DIGIT_W] * mb_reg;
        if (r24_reg) begin
            rounded = ({1'b0, acc_reg} + (PROD_W+1)'(1 << 23)) >> 24;
        end else begin
            rounded = ({1'b0, acc_reg} + (PROD_W+1)'(1 << 15)) >> 16;
        end
        mag = rounded[RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start) begin
                ma_reg   <= abs_a[MUL_A_W-1:0];
                mb_reg   <= abs_b[MUL_B_W-1:0];
                neg_reg  <= req.a[MUL_A_W] ^ req.b[MUL_B_W];
                r24_reg  <= req.round24;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // top digit first: shift the partial sum up as we go
                acc_reg <= (acc_reg << DIGIT_W) + PROD_W'(pp);
                ma_reg  <= ma_reg << DIGIT_W;
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(MUL_DIGITS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                result_reg <= neg_reg ? -$signed(mag) : $signed(mag);
                done_reg   <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

[hdl/ads_check.sv]
// Port-level checker for the stencil block, bound to the top level.
`timescale 1ns / 1ps
module ads_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    // output register is cleared by reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("m_tvalid set after reset");

    // one cell in flight: a request closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second request taken at once");

    // configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready) else $error("config write stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");
endmodule

bind advection_diffusion_stencil_step ads_check u_ads_check (.*);

[tb/ads_checker.sv]
// Checker for the advection-diffusion stencil: predicts each result and compares.
`timescale 1ns / 1ps
module ads_checker
    import ads_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [95:0]          s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [63:0]          m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   cells_owed
);

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DATA_W-1:0] phi;
        logic              last;
    } cell_res_t;

    cell_res_t owed_q[$];

    logic [GW_W-1:0]   grid_w;
    logic [15:0]       grid_h;
    logic [31:0]       ax, ay, kx, ky;
    logic [DATA_W-1:0] phi_rows [0:2*MAX_WIDTH_DEF-1];
    logic [DATA_W-1:0] u_row [0:MAX_WIDTH_DEF-1];
    logic [DATA_W-1:0] v_row [0:MAX_WIDTH_DEF-1];
    int                col_pos, row_pos;

    assign cells_owed = owed_q.size();

    function automatic longint sx(logic [31:0] x);
        return longint'(signed'(x));
    endfunction

    // round(a*b / 2^sh), half away from zero
    function automatic longint mul_rnd(longint a, longint b, int sh);
        logic [127:0] ma, mb, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = 128'(a < 0 ? -a : a);
        mb = 128'(b < 0 ? -b : b);
        p = (ma * mb + (128'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic logic [31:0] sat32(longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ckr: %s mismatch got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_cell(logic [95:0] d);
        int w, h, r, c, cur, prv;
        longint ctr, res, west, east, south, north, gx, gy, adv, dif;
        cell_res_t e;
        w = grid_w;
        h = grid_h;
        r = row_pos;
        c = col_pos;
        if (w < GRID_MIN) w = GRID_MIN;
        if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
        if (h < GRID_MIN) h = GRID_MIN;
        if (c >= MAX_WIDTH_DEF) c = MAX_WIDTH_DEF - 1;
        cur = r & 1;
        prv = cur ^ 1;
        if (r >= 1) begin
            ctr = sx(phi_rows[prv*MAX_WIDTH_DEF + c]);
            res = ctr;
            if (r >= 2 && c >= 1 && c + 1 < w) begin
                west  = sx(phi_rows[prv*MAX_WIDTH_DEF + c - 1]);
                east  = sx(phi_rows[prv*MAX_WIDTH_DEF + c + 1]);
                south = sx(phi_rows[cur*MAX_WIDTH_DEF + c]);
                north = sx(d[31:0]);
                gx  = mul_rnd(east - west, longint'(ax), 24);
                gy  = mul_rnd(north - south, longint'(ay), 24);
                adv = mul_rnd(gx, sx(u_row[c]), 16) + mul_rnd(gy, sx(v_row[c]), 16);
                dif = mul_rnd(east + west - 2 * ctr, longint'(kx), 24)
                    + mul_rnd(north + south - 2 * ctr, longint'(ky), 24);
                res = ctr - adv + dif;
            end
            e.row  = ROW_W'(r - 1);
            e.col  = COL_W'(c);
            e.phi  = sat32(res);
            e.last = !(r + 1 >= h);
            owed_q.push_back(e);
        end
        // bottom row: the incoming cell itself passes straight through
        if (r + 1 >= h) begin
            e.row  = ROW_W'(r);
            e.col  = COL_W'(c);
            e.phi  = d[31:0];
            e.last = 1'b1;
            owed_q.push_back(e);
        end
        phi_rows[cur*MAX_WIDTH_DEF + c] = d[31:0];
        u_row[c] = d[63:32];
        v_row[c] = d[95:64];
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        cell_res_t e;
        if (!aresetn) begin
            grid_w  = GW_W'(GRID_MIN);
            grid_h  = 16'(GRID_MIN);
            ax = 0; ay = 0; kx = 0; ky = 0;
            col_pos = 0;
            row_pos = 0;
            owed_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    e = owed_q.pop_front();
                    if (m_tdata[15:0] != e.row)  report("out_row", m_tdata[15:0], e.row);
                    if (m_tdata[25:16] != e.col) report("out_col", m_tdata[25:16], e.col);
                    if (m_tdata[57:26] != e.phi) report("phi_out", m_tdata[57:26], e.phi);
                    if (m_tlast != e.last)       report("tlast", m_tlast, e.last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH:  grid_w = cfg_data[GW_W-1:0];
                    REG_GRID_HEIGHT: grid_h = cfg_data[15:0];
                    REG_ADV_X:       ax = cfg_data;
                    REG_ADV_Y:       ay = cfg_data;
                    REG_DIFF_X:      kx = cfg_data;
                    REG_DIFF_Y:      ky = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_cell(s_tdata);
        end
    end

endmodule

[tb/tb.sv]
// Testbench top: stimulus, flow control and verdict for the stencil block.
`timescale 1ns / 1ps
module tb;
    import ads_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 120;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
    logic [DATA_W-1:0]    cfg_data = '0;
    int                   fail_count, cells_owed;
    int                   cells_sent = 0;
    int                   burst_left = 0;
    int                   quiet = 0;
    int                   rx_cycle = 0;
    int                   hold_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    advection_diffusion_stencil_step u_top (.*);

    ads_checker u_chk (.*);

    // receiver: changing stall pattern plus two long hold-offs
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle == 3000 || rx_cycle == 90000) hold_left = 600;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 1500) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            default: return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_coeff();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic int clamp_w(int w);
        return w < GRID_MIN ? GRID_MIN : (w > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : w);
    endfunction

    task automatic push_cell(logic [95:0] d);
        s_tdata  = d;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        cells_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 10);
        end
    endtask

    // sender pauses until the block has drained
    task automatic drain();
        s_tvalid = 1'b0;
        while (cells_owed != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic reg_write(cfg_reg_t idx, logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_grid(int w, int h, logic [31:0] a_x, logic [31:0] a_y,
                            logic [31:0] d_x, logic [31:0] d_y);
        drain();
        reg_write(REG_GRID_WIDTH, w);
        reg_write(REG_GRID_HEIGHT, h);
        reg_write(REG_ADV_X, a_x);
        reg_write(REG_ADV_Y, a_y);
        reg_write(REG_DIFF_X, d_x);
        reg_write(REG_DIFF_Y, d_y);
    endtask

    task automatic send_cells(int n);
        for (int i = 0; i < n; i++) push_cell({rand_word(), rand_word(), rand_word()});
    endtask

    initial begin
        int w, h;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extreme data at unit-ish coefficients, then all-ones
        set_grid(3, 3, 32'h0100_0000, 32'h0100_0000, 32'h0040_0000, 32'h0040_0000);
        for (int i = 0; i < 9; i++)
            push_cell({(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000),
                       (i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF),
                       (i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF)});
        // width and height below range act as 3
        set_grid(1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 9; i++)
            push_cell({$urandom, (i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF),
                       (i[1] ? 32'h8000_0000 : 32'h7FFF_FFFF)});

        // shrink width and height part way through a frame
        set_grid(8, 6, rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
        send_cells(3 * 8 + 4);
        drain();
        reg_write(REG_GRID_WIDTH, 4);
        reg_write(REG_GRID_HEIGHT, 2);
        send_cells(1);

        while (cells_sent < 1850 - MAX_WIDTH_DEF - 2) begin
            w = $urandom_range(0, 14);
            h = $urandom_range(0, 6);
            set_grid(w, h, rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
            send_cells(clamp_w(w) * (h < GRID_MIN ? GRID_MIN : h)
                       * $urandom_range(1, 2));
        end

        // width above the maximum acts as the maximum: one full row, then two cells
        set_grid(1100, 0, rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
        send_cells(MAX_WIDTH_DEF + 2);

        drain();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
